### rtl/imufp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imufp_pkg
// Shared types and byte codes for the IMU serial frame parser.
// ----------------------------------------------------------------------------
package imufp_pkg;

  localparam logic [7:0]  HDR_BYTE   = 8'h55;
  localparam logic [7:0]  TYPE_ACC   = 8'h51;
  localparam logic [7:0]  TYPE_RATE  = 8'h52;
  localparam logic [7:0]  TYPE_ANGLE = 8'h53;
  localparam logic [15:0] YAW_OFFSET = 16'hC000;

  // Position of the checksum byte within a frame (header is position 0).
  localparam logic [3:0]  POS_CSUM   = 4'd10;
  // First data byte position and number of stored data bytes.
  localparam logic [3:0]  POS_DATA0  = 4'd2;
  localparam int          NUM_PAY    = 6;

  // The low two bits of a type byte give the frame kind directly.
  typedef enum logic [1:0] {
    KIND_HUNT  = 2'd0,
    KIND_ACC   = 2'd1,
    KIND_RATE  = 2'd2,
    KIND_ANGLE = 2'd3
  } kind_t;

  typedef logic signed [15:0] axis_t;

endpackage

### rtl/imu_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_parser_unit
// Byte-serial parser for 11-byte IMU frames; emits acceleration plus angle
// on every valid angle frame.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                   | moves
//  ---------+-----------------------------------------+--------------------------
//  input    | in_valid, in_ready, in_rx_byte          | one received byte
//  result   | out_valid, out_ready, out_acc_{x,y,z},  | held accel + angle sample
//           | out_angle_{x,y,z}                       |
//
//  Cycles: one byte per clock while in_ready is high; a result appears in the
//  cycle after the checksum byte of a valid angle frame is transferred.
//  Reset: synchronous on rst_n; parser returns to header hunt, held
//  acceleration clears, output register empties.
//  Stalls: the output register holds a waiting result while bytes keep
//  flowing; in_ready drops only when the next byte is a checksum byte and
//  a result is still waiting to be transferred.
//
module imu_frame_parser_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output imufp_pkg::axis_t      out_acc_x,
  output imufp_pkg::axis_t      out_acc_y,
  output imufp_pkg::axis_t      out_acc_z,
  output imufp_pkg::axis_t      out_angle_x,
  output imufp_pkg::axis_t      out_angle_y,
  output imufp_pkg::axis_t      out_angle_z
);
  import imufp_pkg::*;

  // Parser state
  kind_t       kind_r, kind_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  pay_r [NUM_PAY];
  axis_t       acc_r [3];
  axis_t       acc_nxt [3];

  // Output register
  logic        out_valid_r, out_valid_nxt;
  axis_t       res_r [6];

  logic        in_xfer;
  logic        csum_ok;
  logic        emit;
  logic        pay_we;
  logic [2:0]  pay_idx;
  logic [7:0]  b;
  axis_t       word0, word1, word2;

  assign b       = in_rx_byte;
  assign in_xfer = in_valid && in_ready;
  assign csum_ok = (b == sum_r);

  // Block only a checksum byte, and only while the slot it could fill is busy.
  assign in_ready = !((kind_r != KIND_HUNT) && (pos_r == POS_CSUM) &&
                      out_valid_r && !out_ready);

  // Little-endian data words from the stored payload bytes.
  assign word0 = {pay_r[1], pay_r[0]};
  assign word1 = {pay_r[3], pay_r[2]};
  assign word2 = {pay_r[5], pay_r[4]};

  // Data bytes 1..6 are stored; bytes 7 and 8 only feed the sum.
  assign pay_idx = 3'(pos_r - POS_DATA0);
  assign pay_we  = in_xfer && (kind_r != KIND_HUNT) && (pos_r < POS_CSUM) &&
                   (pay_idx < 3'(NUM_PAY));

  assign emit = in_xfer && (kind_r == KIND_ANGLE) && (pos_r == POS_CSUM) && csum_ok;

  // Next-state logic for the parse position, running sum and held accel.
  always_comb begin
    kind_nxt = kind_r;
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i] = acc_r[i];
    end
    if (in_xfer) begin
      if (kind_r == KIND_HUNT) begin
        if ((pos_r == 4'd1) &&
            ((b == TYPE_ACC) || (b == TYPE_RATE) || (b == TYPE_ANGLE))) begin
          kind_nxt = kind_t'(b[1:0]);
          sum_nxt  = sum_r + b;
          pos_nxt  = POS_DATA0;
        end else if (b == HDR_BYTE) begin
          // A header byte always (re)starts a frame.
          sum_nxt = HDR_BYTE;
          pos_nxt = 4'd1;
        end else begin
          sum_nxt = '0;
          pos_nxt = '0;
        end
      end else if (pos_r < POS_CSUM) begin
        sum_nxt = sum_r + b;
        pos_nxt = pos_r + 4'd1;
      end else begin
        // Checksum byte: commit acceleration, or clear it at any angle frame end.
        if ((kind_r == KIND_ACC) && csum_ok) begin
          acc_nxt[0] = word0;
          acc_nxt[1] = word1;
          acc_nxt[2] = word2;
        end else if (kind_r == KIND_ANGLE) begin
          for (int i = 0; i < 3; i++) begin
            acc_nxt[i] = '0;
          end
        end
        kind_nxt = KIND_HUNT;
        pos_nxt  = '0;
        sum_nxt  = '0;
      end
    end
  end

  // Output handshake: fill on emit, drain on transfer.
  always_comb begin
    out_valid_nxt = emit || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= KIND_HUNT;
      pos_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      kind_r      <= kind_nxt;
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 3; i++) begin
        acc_r[i] <= acc_nxt[i];
      end
    end
  end

  // Payload bytes: no reset, every entry is written before the checksum reads it.
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_PAY; i++) begin
      if (pay_we && (pay_idx == 3'(i))) begin
        pay_r[i] <= b;
      end
    end
  end

  // Result register: load on emit, hold otherwise.
  always_ff @(posedge clk) begin
    if (emit) begin
      res_r[0] <= acc_r[0];
      res_r[1] <= acc_r[1];
      res_r[2] <= acc_r[2];
      res_r[3] <= word0;
      res_r[4] <= word1;
      res_r[5] <= YAW_OFFSET - word2;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_acc_x   = res_r[0];
  assign out_acc_y   = res_r[1];
  assign out_acc_z   = res_r[2];
  assign out_angle_x = res_r[3];
  assign out_angle_y = res_r[4];
  assign out_angle_z = res_r[5];

endmodule

### rtl/imufp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imufp_checker
// Port-level assertions for the IMU frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module imufp_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [7:0]            in_rx_byte,
  input logic                  out_valid,
  input logic                  out_ready,
  input imufp_pkg::axis_t      out_acc_x,
  input imufp_pkg::axis_t      out_acc_y,
  input imufp_pkg::axis_t      out_acc_z,
  input imufp_pkg::axis_t      out_angle_x,
  input imufp_pkg::axis_t      out_angle_y,
  input imufp_pkg::axis_t      out_angle_z
);
  import imufp_pkg::*;

  // Hold a stalled input byte unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_rx_byte))
    else $error("stalled input byte changed");

  // Hold a stalled result unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_acc_x) &&
      $stable(out_acc_y) && $stable(out_acc_z) && $stable(out_angle_x) &&
      $stable(out_angle_y) && $stable(out_angle_z))
    else $error("stalled result changed");

  // Empty output after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result only follows a byte transfer.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without a byte transfer");

  // Input back-pressure only while a result is stuck.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

endmodule

bind imu_frame_parser_unit imufp_checker u_imufp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_rx_byte  (in_rx_byte),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_acc_x   (out_acc_x),
  .out_acc_y   (out_acc_y),
  .out_acc_z   (out_acc_z),
  .out_angle_x (out_angle_x),
  .out_angle_y (out_angle_y),
  .out_angle_z (out_angle_z)
);

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IMU frame parser. A queue of serial bytes
// (directed frames first, then mostly well-formed random frames mixed with
// noise and broken headers) feeds a valid/ready driver. A parser model of its
// own tracks every transferred byte and queues the angle samples it expects.
// A monitor compares each result transfer field by field. Both sides idle at
// random, with one quiet stretch where neither side idles.
// ----------------------------------------------------------------------------
module tb;
  import imufp_pkg::*;

  typedef struct packed {
    axis_t acc_x;
    axis_t acc_y;
    axis_t acc_z;
    axis_t angle_x;
    axis_t angle_y;
    axis_t angle_z;
  } angle_sample_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  axis_t      out_acc_x;
  axis_t      out_acc_y;
  axis_t      out_acc_z;
  axis_t      out_angle_x;
  axis_t      out_angle_y;
  axis_t      out_angle_z;

  // Bytes waiting to be driven, and samples the parser model says must come.
  logic [7:0]    byte_queue[$];
  angle_sample_t samples_due[$];

  int error_count;
  int bytes_sent;
  int frames_built;
  int samples_checked;

  // Parser model state.
  kind_t      hunt_kind;
  logic [3:0] frame_pos;
  logic [7:0] frame_sum;
  logic [7:0] data_bytes[NUM_PAY];
  axis_t      accel_held[3];

  imu_frame_parser_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_acc_x  (out_acc_x),
    .out_acc_y  (out_acc_y),
    .out_acc_z  (out_acc_z),
    .out_angle_x(out_angle_x),
    .out_angle_y(out_angle_y),
    .out_angle_z(out_angle_z)
  );

  always #5 clk = ~clk;

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what);
    error_count++;
    $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input axis_t got, input axis_t want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h want %h (sample %0d)",
                                name, got, want, samples_checked));
    end
  endtask

  // Append one byte to the tail of the byte queue.
  task automatic queue_byte(input logic [7:0] v);
    byte_queue.insert(byte_queue.size(), v);
  endtask

  // Drop back to header hunt.
  task automatic restart_hunt();
    hunt_kind = KIND_HUNT;
    frame_pos = 4'd0;
    frame_sum = 8'h00;
  endtask

  function automatic logic [15:0] data_word(input logic [1:0] idx);
    return {data_bytes[{idx, 1'b1}], data_bytes[{idx, 1'b0}]};
  endfunction

  // Advance the parser model by one transferred byte; queue a sample when a
  // valid angle frame closes.
  task automatic parse_byte(input logic [7:0] b);
    angle_sample_t s;
    logic          sum_ok;
    logic [3:0]    rel_pos;
    if (hunt_kind == KIND_HUNT) begin
      if (frame_pos == 4'd1 && (b == TYPE_ACC || b == TYPE_RATE || b == TYPE_ANGLE)) begin
        // Type byte: the low two bits name the frame kind.
        hunt_kind = kind_t'(b[1:0]);
        frame_sum = frame_sum + b;
        frame_pos = POS_DATA0;
      end else if (b == HDR_BYTE) begin
        // A header, possibly right after another header.
        frame_sum = HDR_BYTE;
        frame_pos = 4'd1;
      end else begin
        restart_hunt();
      end
    end else if (frame_pos < POS_CSUM) begin
      // Store the first six data bytes; bytes seven and eight only add to the sum.
      rel_pos = frame_pos - POS_DATA0;
      if (rel_pos < 4'(NUM_PAY)) data_bytes[rel_pos[2:0]] = b;
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      sum_ok = (b == frame_sum);
      if (hunt_kind == KIND_ACC && sum_ok) begin
        for (int i = 0; i < 3; i++) accel_held[i] = data_word(2'(i));
      end else if (hunt_kind == KIND_ANGLE) begin
        if (sum_ok) begin
          s.acc_x   = accel_held[0];
          s.acc_y   = accel_held[1];
          s.acc_z   = accel_held[2];
          s.angle_x = data_word(2'd0);
          s.angle_y = data_word(2'd1);
          s.angle_z = YAW_OFFSET - data_word(2'd2);
          samples_due.insert(samples_due.size(), s);
        end
        // Every angle frame end clears the held acceleration, good or bad.
        for (int i = 0; i < 3; i++) accel_held[i] = '0;
      end
      restart_hunt();
    end
  endtask

  // Queue one full frame; optionally spoil its checksum.
  task automatic push_frame(input logic [7:0] type_byte, input logic [15:0] w0,
                            input logic [15:0] w1, input logic [15:0] w2,
                            input logic [15:0] w3, input bit bad_sum);
    logic [7:0] bytes[11];
    logic [7:0] sum;
    bytes[0] = HDR_BYTE;
    bytes[1] = type_byte;
    {bytes[3], bytes[2]} = w0;
    {bytes[5], bytes[4]} = w1;
    {bytes[7], bytes[6]} = w2;
    {bytes[9], bytes[8]} = w3;
    sum = 8'h00;
    for (int i = 0; i < 10; i++) sum = sum + bytes[i];
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    bytes[10] = sum;
    for (int i = 0; i < 11; i++) queue_byte(bytes[i]);
    frames_built++;
  endtask

  // Random word, leaning on the corners now and then.
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Idle with a chance of about 16 in 100, but never in the quiet stretch.
  function automatic bit idle_now();
    if (bytes_sent >= 700 && bytes_sent < 1000) return 1'b0;
    return $urandom_range(0, 99) < 16;
  endfunction

  // Driver: hold a byte until it transfers, then advance to the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_rx_byte);
        bytes_sent++;
      end
      if (!in_valid || in_ready) begin
        if (byte_queue.size() > 0 && !idle_now()) begin
          in_rx_byte <= byte_queue[0];
          byte_queue.delete(0);
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random and check each result transfer in order.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (samples_due.size() == 0) begin
          report_mismatch("result with no sample expected");
        end else begin
          check_field("acc_x", out_acc_x, samples_due[0].acc_x);
          check_field("acc_y", out_acc_y, samples_due[0].acc_y);
          check_field("acc_z", out_acc_z, samples_due[0].acc_z);
          check_field("angle_x", out_angle_x, samples_due[0].angle_x);
          check_field("angle_y", out_angle_y, samples_due[0].angle_y);
          check_field("angle_z", out_angle_z, samples_due[0].angle_z);
          samples_due.delete(0);
          samples_checked++;
        end
      end
      out_ready <= !idle_now();
    end
  end

  // Hard stop in case the run hangs.
  initial begin
    #2_000_000;
    $display("tb: timeout with %0d samples outstanding", samples_due.size());
    $display("tb: errors");
    $finish;
  end

  initial begin
    int         pick;
    logic [7:0] junk;
    logic [7:0] type_byte;

    error_count     = 0;
    bytes_sent      = 0;
    frames_built    = 0;
    samples_checked = 0;
    restart_hunt();
    for (int i = 0; i < NUM_PAY; i++) data_bytes[i] = 8'h00;
    for (int i = 0; i < 3; i++) accel_held[i] = '0;

    // Directed: noise while hunting, including a bare type byte.
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(TYPE_ANGLE);
    // Angle frame with nothing held; yaw raw zero maps to 0xC000.
    push_frame(TYPE_ANGLE, 16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 1'b0);
    // Acceleration at the corners, then an angle frame that reads it.
    push_frame(TYPE_ACC, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_frame(TYPE_ANGLE, 16'h0000, 16'hFFFF, 16'hC000, 16'h0000, 1'b0);
    // Held acceleration was cleared by the last angle frame.
    push_frame(TYPE_ANGLE, 16'h1234, 16'h5678, 16'hFFFF, 16'h0000, 1'b0);
    // A rate frame between acceleration and angle leaves the held value.
    push_frame(TYPE_ACC, 16'h0001, 16'hFFFE, 16'h4000, 16'h5555, 1'b0);
    push_frame(TYPE_RATE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    push_frame(TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'hC001, 16'h0000, 1'b0);
    // A bad angle checksum still clears the held acceleration.
    push_frame(TYPE_ACC, 16'h2222, 16'h3333, 16'h4444, 16'h0000, 1'b0);
    push_frame(TYPE_ANGLE, 16'h1111, 16'h1111, 16'h1111, 16'h0000, 1'b1);
    push_frame(TYPE_ANGLE, 16'h0102, 16'h0304, 16'h0506, 16'h0708, 1'b0);
    // A bad acceleration checksum keeps the old held value.
    push_frame(TYPE_ACC, 16'h0A0A, 16'h0B0B, 16'h0C0C, 16'h0000, 1'b0);
    push_frame(TYPE_ACC, 16'hDEAD, 16'hBEEF, 16'hCAFE, 16'h0000, 1'b1);
    push_frame(TYPE_ANGLE, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b0);
    // Header then a bad type byte restarts the hunt.
    queue_byte(HDR_BYTE);
    queue_byte(8'h54);
    // Header then header: the second one starts the frame.
    queue_byte(HDR_BYTE);
    push_frame(TYPE_ANGLE, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 1'b0);
    // Rate frame with a bad checksum.
    push_frame(TYPE_RATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);

    // Random: mostly well-formed frames, some noise and broken headers.
    while (byte_queue.size() < 1600) begin
      pick = $urandom_range(0, 99);
      if (pick < 7) begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
      end else if (pick < 13) begin
        // Broken header: anything but a type byte, 0x55 included.
        queue_byte(HDR_BYTE);
        do junk = 8'($urandom);
        while (junk == TYPE_ACC || junk == TYPE_RATE || junk == TYPE_ANGLE);
        if ($urandom_range(0, 3) == 0) junk = HDR_BYTE;
        queue_byte(junk);
      end else if (pick < 17) begin
        // Truncated frame: the next frame's bytes land in its data.
        queue_byte(HDR_BYTE);
        queue_byte(8'(TYPE_ACC + $urandom_range(0, 2)));
        repeat ($urandom_range(0, 8)) queue_byte(8'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        type_byte = (pick < 40) ? TYPE_ACC : (pick < 55) ? TYPE_RATE : TYPE_ANGLE;
        push_frame(type_byte, rand_word(), rand_word(), rand_word(), rand_word(),
                   $urandom_range(0, 9) == 0);
      end
    end

    // Hold reset at first, then release it for good.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain input, then wait for every expected sample, then a short tail.
    while (byte_queue.size() > 0 || in_valid) @(posedge clk);
    while (samples_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("tb: %0d bytes transferred over %0d frames, %0d angle samples checked",
             bytes_sent, frames_built, samples_checked);
    $display("tb: %0d mismatches, %0d samples still due", error_count, samples_due.size());
    if (error_count == 0 && samples_due.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
